>>> hw/rtl/adl_pkg.sv
`default_nettype none
package adl_pkg;

  localparam logic [16:0] ADLER_MOD   = 17'd65521;
  localparam int          WORD_BYTES  = 4;
  localparam int          LANES_DEF   = 4;
  localparam int          QUEUE_DEF   = 2;
  // count <= 4 and sums reduced: B + n*A + W stays below 6 * modulus
  localparam int          REDUCE_MAX  = 5;

  // One classified item: last flag, byte count, plain byte total and position-weighted
  // total, so the back end closes the sums in one step.
  typedef struct packed {
    logic        last;
    logic [2:0]  cnt;
    logic [9:0]  byte_total;
    logic [11:0] weighted;
  } adl_item_t;

endpackage
`default_nettype wire

>>> hw/rtl/adl_front.sv
`default_nettype none
module adl_front #(
  parameter int LANES = adl_pkg::LANES_DEF
) (
  input  wire logic             in_valid,
  input  wire logic [31:0]      in_data_bytes,
  input  wire logic [2:0]       in_valid_bytes,
  input  wire logic             in_last_item,
  output logic                  in_stall,
  input  wire logic             q_full,
  output logic                  q_push,
  output adl_pkg::adl_item_t    q_item
);
  import adl_pkg::*;

  localparam int LANE_CNT = (LANES < WORD_BYTES) ? LANES : WORD_BYTES;
  localparam logic [2:0] LIMIT = 3'(LANE_CNT);

  logic [2:0]  cnt;
  logic [9:0]  total;
  logic [11:0] weighted;

  always_comb begin
    cnt = (in_valid_bytes > LIMIT) ? LIMIT : in_valid_bytes;
    total = '0;
    weighted = '0;
    // byte k contributes (cnt - k) times to the second sum
    for (int k = 0; k < WORD_BYTES; k++) begin
      if (3'(k) < cnt) begin
        total = total + 10'(in_data_bytes[8*k +: 8]);
        weighted = weighted + 12'(in_data_bytes[8*k +: 8]) * 12'(cnt - 3'(k));
      end
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.last       = in_last_item;
    q_item.cnt        = cnt;
    q_item.byte_total = total;
    q_item.weighted   = weighted;
  end

endmodule
`default_nettype wire

>>> hw/rtl/adl_queue.sv
`default_nettype none
module adl_queue #(
  parameter int DEPTH = adl_pkg::QUEUE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire adl_pkg::adl_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output adl_pkg::adl_item_t      pop_item,
  output logic                    empty
);
  import adl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  adl_item_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/adl_back.sv
`default_nettype none
module adl_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire adl_pkg::adl_item_t q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  output logic [31:0]             out_checksum,
  input  wire logic               out_stall
);
  import adl_pkg::*;

  logic [15:0] a_r, a_nxt;
  logic [15:0] b_r, b_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_checksum_r;
  logic [16:0] a_sum;
  logic [19:0] na;
  logic [19:0] b_raw;
  logic [19:0] b_red;
  logic        emit;

  // a result can only be taken when the output register is free or draining
  assign q_pop = !q_empty && (!q_item.last || !out_valid_r || !out_stall);
  assign emit  = q_pop && q_item.last;

  always_comb begin
    a_sum = {1'b0, a_r} + 17'(q_item.byte_total);
    a_nxt = (a_sum >= ADLER_MOD) ? 16'(a_sum - ADLER_MOD) : a_sum[15:0];

    // B + n*A + weighted, then pick the largest multiple of the modulus below it
    na = (q_item.cnt[0] ? 20'(a_r) : 20'd0)
       + (q_item.cnt[1] ? (20'(a_r) << 1) : 20'd0)
       + (q_item.cnt[2] ? (20'(a_r) << 2) : 20'd0);
    b_raw = 20'(b_r) + na + 20'(q_item.weighted);
    b_red = b_raw;
    for (int k = 1; k <= REDUCE_MAX; k++) begin
      if (b_raw >= 20'(k * ADLER_MOD)) begin
        b_red = b_raw - 20'(k * ADLER_MOD);
      end
    end
    b_nxt = b_red[15:0];
  end

  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r         <= 16'd1;
      b_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        a_r <= 16'd1;
        b_r <= '0;
      end else if (q_pop) begin
        a_r <= a_nxt;
        b_r <= b_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_checksum_r <= {b_nxt, a_nxt};
    end
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = out_checksum_r;

endmodule
`default_nettype wire

>>> hw/rtl/adler32_checksum.sv
// Adler-32 checksum over a byte stream delivered as 32-bit words.
// Input channel: in_data_bytes carries up to four bytes, first byte in
// bits 7:0; in_valid_bytes gives how many are used from the low end (values
// above min(LANES, 4) saturate); in_last_item closes the message. A transfer
// happens when in_valid is high and in_stall is low.
// Output channel: one out_checksum per message, {sum2, sum1}, presented on
// out_valid and held until a cycle with out_stall low.
// Throughput: one input word per cycle while in_stall is low. A word is classified on entry, held
// in a queue of QUEUE_DEPTH entries (two by default), and folded into both sums by the
// back end, which closes the sums with one add and a compare-select against
// multiples of 65521.
// Output path: the last word passes through the queue and the back end's output register
// before its checksum appears on the outputs, when nothing is queued ahead of it.
// Stall: while a checksum waits, non-last words keep flowing; a further last
// word waits in the queue, and once the queue fills, in_stall rises.
// Reset (rst_n low, synchronous): queue empties, no result is pending and the
// sums return to 1 and 0. An empty message yields 0x00000001.
`default_nettype none
module adler32_checksum #(
  parameter int LANES       = adl_pkg::LANES_DEF,
  parameter int QUEUE_DEPTH = adl_pkg::QUEUE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_data_bytes,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic        in_last_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_checksum
);
  import adl_pkg::*;

  adl_item_t push_item;
  adl_item_t pop_item;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;

  adl_front #(
    .LANES (LANES)
  ) u_front (
    .in_valid       (in_valid),
    .in_data_bytes  (in_data_bytes),
    .in_valid_bytes (in_valid_bytes),
    .in_last_item   (in_last_item),
    .in_stall       (in_stall),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  adl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  adl_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_item       (pop_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_checksum (out_checksum),
    .out_stall    (out_stall)
  );

endmodule
`default_nettype wire

>>> dv/adler32_checksum_test.sv
module adler32_checksum_test;

  localparam int          MAX_CYCLES = 400000;
  localparam int          WORD_LIMIT = (adl_pkg::LANES_DEF < adl_pkg::WORD_BYTES) ?
                                       adl_pkg::LANES_DEF : adl_pkg::WORD_BYTES;
  localparam logic [16:0] MODULUS    = adl_pkg::ADLER_MOD;

  typedef struct {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_data_bytes = '0;
  logic [2:0]  in_valid_bytes = '0;
  logic        in_last_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_checksum;

  word_t       pending_words[$];
  logic [31:0] expected_checksums[$];

  // checksum state mirrored from the transfers seen on the input side
  logic [15:0] sum_a = 16'd1;
  logic [15:0] sum_b = 16'd0;

  int          errors = 0;
  int          words_sent = 0;
  int          msgs_sent = 0;
  int          sums_checked = 0;
  int          cycles = 0;
  int          in_gap = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;

  adler32_checksum DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_bytes (in_data_bytes),
    .in_valid_bytes(in_valid_bytes),
    .in_last_item  (in_last_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_checksum  (out_checksum)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic adler_absorb(input logic [31:0] data, input logic [2:0] cnt,
                              input logic last);
    int unsigned n;
    logic [16:0] s;
    n = (cnt > WORD_LIMIT) ? WORD_LIMIT : cnt;
    for (int k = 0; k < n; k++) begin
      s = sum_a + data[8*k +: 8];
      if (s >= MODULUS) s = s - MODULUS;
      sum_a = s[15:0];
      s = sum_b + sum_a;
      if (s >= MODULUS) s = s - MODULUS;
      sum_b = s[15:0];
    end
    if (last) begin
      expected_checksums.push_back({sum_b, sum_a});
      sum_a = 16'd1;
      sum_b = 16'd0;
      msgs_sent++;
    end
  endtask

  function automatic word_t mk(input logic [31:0] d, input logic [2:0] c, input logic l);
    word_t w;
    w.data = d;
    w.cnt  = c;
    w.last = l;
    return w;
  endfunction

  // stretches of back-to-back traffic on both sides
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 300 == 0) no_idle <= ($urandom_range(0, 3) == 0);
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    logic  nxt_valid;
    word_t w;
    nxt_valid = in_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        adler_absorb(in_data_bytes, in_valid_bytes, in_last_item);
        words_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_data_bytes  <= w.data;
          in_valid_bytes <= w.cnt;
          in_last_item   <= w.last;
          nxt_valid = 1'b1;
          in_gap = pick_gap();
        end
      end
    end
    in_valid <= nxt_valid;
  end

  // monitor
  always @(posedge clk) begin
    logic [31:0] exp_sum;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_checksums.size() == 0) begin
          $display("%0t: unexpected checksum transfer, actual %h", $time, out_checksum);
          errors++;
        end else begin
          exp_sum = expected_checksums.pop_front();
          sums_checked++;
          if (out_checksum !== exp_sum) begin
            $display("%0t: checksum mismatch, expected %h actual %h",
                     $time, exp_sum, out_checksum);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    int    len, r, n_items;
    bit    dense;
    word_t w;

    // directed: empty message, masked upper bytes, saturating counts, empty words
    pending_words.push_back(mk(32'h0000_0000, 3'd0, 1'b1));
    pending_words.push_back(mk(32'hFFFF_FFFF, 3'd1, 1'b1));
    pending_words.push_back(mk(32'hFFFF_FFFF, 3'd4, 1'b0));
    pending_words.push_back(mk(32'hDEAD_BEEF, 3'd0, 1'b0));
    pending_words.push_back(mk(32'h0102_0304, 3'd7, 1'b0));
    pending_words.push_back(mk(32'h0000_0000, 3'd5, 1'b1));
    pending_words.push_back(mk(32'h8080_8080, 3'd2, 1'b0));
    pending_words.push_back(mk(32'h7F7F_7F7F, 3'd3, 1'b0));
    pending_words.push_back(mk(32'hA5A5_A5A5, 3'd6, 1'b1));
    pending_words.push_back(mk(32'hFFFF_FFFF, 3'd4, 1'b0));
    pending_words.push_back(mk(32'hFFFF_FFFF, 3'd4, 1'b0));
    pending_words.push_back(mk(32'hFFFF_FFFF, 3'd4, 1'b0));
    pending_words.push_back(mk(32'hFFFF_FFFF, 3'd4, 1'b1));
    pending_words.push_back(mk(32'h1234_5678, 3'd0, 1'b0));
    pending_words.push_back(mk(32'h0000_0000, 3'd0, 1'b1));
    pending_words.push_back(mk(32'hFFFF_FF00, 3'd1, 1'b1));
    pending_words.push_back(mk(32'h5555_5555, 3'd4, 1'b0));
    pending_words.push_back(mk(32'hAAAA_AAAA, 3'd4, 1'b1));
    n_items = pending_words.size();

    // random messages; the occasional long dense one drives both sums past the modulus
    while (n_items < 1050) begin
      r = $urandom_range(0, 19);
      len = (r == 0) ? $urandom_range(70, 200) : $urandom_range(1, 10);
      dense = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < len; k++) begin
        w.data = dense ? (32'hFFFF_FFFF ^ ($urandom_range(0, 3) == 0 ? $urandom : 32'h0))
                       : $urandom;
        w.cnt  = ($urandom_range(0, 9) < 7) ? 3'd4 : 3'($urandom_range(0, 7));
        w.last = (k == len - 1);
        pending_words.push_back(w);
      end
      n_items += len;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() > 0 || in_valid) @(posedge clk);
    while (expected_checksums.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d words in %0d messages sent, %0d checksums compared", words_sent,
             msgs_sent, sums_checked);
    $display("covered empty and saturating byte counts, masked bytes, modulus wrap");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/adl_pkg.sv
hw/rtl/adl_front.sv
hw/rtl/adl_queue.sv
hw/rtl/adl_back.sv
hw/rtl/adler32_checksum.sv
dv/adler32_checksum_test.sv
